// ----- rtl/core/delta_carriage_position_unit_macros.svh -----
// Assertion macros used by the delta carriage position unit top level.
`ifndef DELTA_CARRIAGE_POSITION_UNIT_MACROS_SVH
`define DELTA_CARRIAGE_POSITION_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define DCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("delta carriage position assertion failed");

// Condition that must hold in the cycle after reset is applied.
`define DCP_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("delta carriage position reset assertion failed");

`endif

// ----- rtl/core/dcp_pkg.sv -----
// Package with widths, register codes and payload types of the delta carriage position unit.
package dcp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 27;
  localparam int COEF_W     = 19;
  localparam int ARM_W      = 52;
  localparam int POS_W      = 28;
  localparam int PROD_W     = COORD_W + COEF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int EX_W       = SUM_W - FRAC_BITS;
  localparam int EZ_W       = PROD_W - FRAC_BITS;
  localparam int D_W        = EX_W + 1;
  localparam int MAG_W      = COORD_W + 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int ROOT_W     = ARM_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int OUT_SUM_W  = EZ_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ARM_W;

  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
  localparam int ONE_FIXED  = 1 << FRAC_BITS;

  localparam logic [D_W-1:0] DIST_LIMIT = D_W'(1) << (MAG_W - 1);
  localparam logic signed [OUT_SUM_W-1:0] SAT_HI = (OUT_SUM_W'(1) << (POS_W - 1)) - 1'b1;
  localparam logic signed [OUT_SUM_W-1:0] SAT_LO = -(OUT_SUM_W'(1) << (POS_W - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARM_LENGTH_SQUARED = 3'd0,
    REG_TOWER_POS_X        = 3'd1,
    REG_TOWER_POS_Y        = 3'd2,
    REG_ROT_COS            = 3'd3,
    REG_ROT_SIN            = 3'd4,
    REG_HEIGHT_GAIN        = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        [ARM_W-1:0]   arm2;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic signed [COEF_W-1:0]  rot_cos;
    logic signed [COEF_W-1:0]  rot_sin;
    logic signed [COEF_W-1:0]  gain;
  } cfg_t;

  typedef struct packed {
    logic        [ARM_W-1:0]  rad;
    logic        [REM_W-1:0]  rem;
    logic        [ROOT_W-1:0] root;
    logic signed [EZ_W-1:0]   ez;
    logic                     unreach;
  } sq_t;

endpackage

// ----- rtl/core/delta_carriage_position_unit.sv -----
// Four front stages (multiply, round, square, radicand), 26 root cells, one output register.
// Throughput: one request per cycle while out_ready is high; each stage moves on when it is empty or drained.
// Reset clears all stage valid bits and loads the configuration reset values.
// Top level of the delta carriage position unit.
`include "delta_carriage_position_unit_macros.svh"

module delta_carriage_position_unit import dcp_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_W-1:0]    coord_x,
  input  logic signed [COORD_W-1:0]    coord_y,
  input  logic signed [COORD_W-1:0]    coord_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [POS_W-1:0]      carriage_pos,
  output logic                         unreachable
);

  cfg_t            cfg;
  logic [ROOT_W:0] sq_valid;
  logic [ROOT_W:0] sq_ready;
  sq_t             sq_data [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm2    <= '0;
      cfg.tx      <= '0;
      cfg.ty      <= '0;
      cfg.rot_cos <= COEF_W'(ONE_FIXED);
      cfg.rot_sin <= '0;
      cfg.gain    <= COEF_W'(ONE_FIXED);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ARM_LENGTH_SQUARED: cfg.arm2    <= cfg_data[ARM_W-1:0];
        REG_TOWER_POS_X:        cfg.tx      <= cfg_data[COORD_W-1:0];
        REG_TOWER_POS_Y:        cfg.ty      <= cfg_data[COORD_W-1:0];
        REG_ROT_COS:            cfg.rot_cos <= cfg_data[COEF_W-1:0];
        REG_ROT_SIN:            cfg.rot_sin <= cfg_data[COEF_W-1:0];
        REG_HEIGHT_GAIN:        cfg.gain    <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  dcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .out_valid (sq_valid[0]),
    .out_ready (sq_ready[0]),
    .out_data  (sq_data[0])
  );

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    dcp_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_valid[i]),
      .in_ready  (sq_ready[i]),
      .in_data   (sq_data[i]),
      .out_valid (sq_valid[i+1]),
      .out_ready (sq_ready[i+1]),
      .out_data  (sq_data[i+1])
    );
  end

  dcp_output u_output (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (sq_valid[ROOT_W]),
    .in_ready     (sq_ready[ROOT_W]),
    .in_data      (sq_data[ROOT_W]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .carriage_pos (carriage_pos),
    .unreachable  (unreachable)
  );

  `DCP_ASSERT_IMP(a_ready_flows_back, out_ready, in_ready)
  `DCP_ASSERT_IMP(a_unreachable_zero, out_valid && unreachable, carriage_pos == '0)
  `DCP_ASSERT_IMP(a_root_remainder, sq_valid[ROOT_W], (sq_data[ROOT_W].rem <= {1'b0, sq_data[ROOT_W].root, 1'b0}))
  `DCP_ASSERT_RST(a_reset_empty, !out_valid && in_ready)

endmodule

// ----- rtl/core/dcp_front.sv -----
// Front pipeline: coordinate rotation, rounding, squared distance and radicand.
module dcp_front import dcp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sq_t                       out_data
);

  logic v0, v1, v2, v3;
  logic en0, en1, en2, en3;

  logic signed [PROD_W-1:0] pcx, psy, psx, pcy, pgz;
  logic signed [D_W-1:0]    dx, dy;
  logic signed [EZ_W-1:0]   ez1, ez2, ez3;
  logic        [SQ_W-1:0]   sqx, sqy;
  logic        [ARM_W-1:0]  rad;
  logic                     unreach;

  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [PROD_W-1:0] rnd_z;
  logic signed [EX_W-1:0]   ex, ey;
  logic        [D_W-1:0]    mag_x, mag_y;
  logic        [MAG_W-1:0]  clp_x, clp_y;
  logic        [DIST_W-1:0] dist_sq;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_ready = en0;

  assign sum_x = (SUM_W'(pcx) - SUM_W'(psy)) + SUM_W'(ROUND_HALF);
  assign sum_y = (SUM_W'(psx) + SUM_W'(pcy)) + SUM_W'(ROUND_HALF);
  assign rnd_z = pgz + PROD_W'(ROUND_HALF);
  assign ex    = sum_x[SUM_W-1:FRAC_BITS];
  assign ey    = sum_y[SUM_W-1:FRAC_BITS];

  assign mag_x = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
  assign mag_y = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
  assign clp_x = (mag_x > DIST_LIMIT) ? MAG_W'(DIST_LIMIT) : mag_x[MAG_W-1:0];
  assign clp_y = (mag_y > DIST_LIMIT) ? MAG_W'(DIST_LIMIT) : mag_y[MAG_W-1:0];

  assign dist_sq = DIST_W'(sqx) + DIST_W'(sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      pcx <= cfg.rot_cos * coord_x;
      psy <= cfg.rot_sin * coord_y;
      psx <= cfg.rot_sin * coord_x;
      pcy <= cfg.rot_cos * coord_y;
      pgz <= cfg.gain * coord_z;
    end
    if (en1) begin
      dx  <= D_W'(cfg.tx) - D_W'(ex);
      dy  <= D_W'(cfg.ty) - D_W'(ey);
      ez1 <= rnd_z[PROD_W-1:FRAC_BITS];
    end
    if (en2) begin
      sqx <= clp_x * clp_x;
      sqy <= clp_y * clp_y;
      ez2 <= ez1;
    end
    if (en3) begin
      unreach <= dist_sq > DIST_W'(cfg.arm2);
      rad     <= cfg.arm2 - dist_sq[ARM_W-1:0];
      ez3     <= ez2;
    end
  end

  assign out_valid        = v3;
  assign out_data.rad     = rad;
  assign out_data.rem     = '0;
  assign out_data.root    = '0;
  assign out_data.ez      = ez3;
  assign out_data.unreach = unreach;

endmodule

// ----- rtl/core/dcp_sqrt_cell.sv -----
// One square root cell: resolves one root bit and passes the partial result on.
module dcp_sqrt_cell import dcp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sq_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output sq_t  out_data
);

  logic              valid;
  sq_t               data;
  sq_t               data_next;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              take;

  assign in_ready = !valid || out_ready;

  assign rem_sh = {in_data.rem, in_data.rad[ARM_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({in_data.root, 2'b01});
  assign take   = rem_sh >= trial;

  always_comb begin
    data_next     = in_data;
    data_next.rad = {in_data.rad[ARM_W-3:0], 2'b00};
    if (take) begin
      data_next.rem  = REM_W'(rem_sh - trial);
      data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_next.rem  = rem_sh[REM_W-1:0];
      data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ----- rtl/core/dcp_output.sv -----
// Output stage: adds the scaled height to the root, saturates, gives zero when unreachable and holds the result.
module dcp_output import dcp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sq_t                     in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] carriage_pos,
  output logic                    unreachable
);

  logic signed [OUT_SUM_W-1:0] sum;
  logic signed [POS_W-1:0]     pos_next;

  assign in_ready = !out_valid || out_ready;

  assign sum = $signed({{(OUT_SUM_W - ROOT_W){1'b0}}, in_data.root}) + OUT_SUM_W'(in_data.ez);

  always_comb begin
    if (in_data.unreach) begin
      pos_next = '0;
    end else if (sum > SAT_HI) begin
      pos_next = POS_W'(SAT_HI);
    end else if (sum < SAT_LO) begin
      pos_next = POS_W'(SAT_LO);
    end else begin
      pos_next = sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      carriage_pos <= pos_next;
      unreachable  <= in_data.unreach;
    end
  end

endmodule
